/* hw/rtl/pgr_pkg.sv */
// Shared types and constants for the palette gradient ramp.
// Used by pgr_chan and palette_gradient_ramp; no dependencies.
package pgr_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ADD
  } pgr_state_t;

  // sequencer strobes shared by the three colour channels
  typedef struct packed {
    logic load;
    logic div_step;
    logic add_step;
    logic add_first;
  } pgr_ctrl_t;

  localparam int CHAN_W = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INDEX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_INDEX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_BLUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_RED     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_GREEN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_BLUE    = 3'd7;

endpackage

/* hw/rtl/pgr_chan.sv */
// One colour channel of the ramp: bit-serial step divider and bit-serial accumulator.
// Depends on pgr_pkg; driven by the sequencer in palette_gradient_ramp.
module pgr_chan
  import pgr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  pgr_ctrl_t         ctrl,
  input  logic [CHAN_W-1:0] from_c,
  input  logic [CHAN_W-1:0] to_c,
  input  logic [CHAN_W-1:0] span,
  output logic [CHAN_W-1:0] colour
);

  localparam int W = CHAN_W + FRAC_BITS;

  logic [W-1:0]      acc_r;
  logic [W-1:0]      step_r;   // step magnitude; sign held in neg_r
  logic [W-1:0]      num_r;
  logic [CHAN_W-1:0] rem_r;
  logic              neg_r;
  logic              carry_r;

  logic [CHAN_W-1:0] mag;
  logic [CHAN_W:0]   trial;
  logic [CHAN_W:0]   trial_sub;
  logic              ge;
  logic              b_bit;
  logic              c_in;
  logic              s_bit;
  logic              c_out;

  always_comb begin
    mag       = (to_c < from_c) ? (from_c - to_c) : (to_c - from_c);
    trial     = {rem_r, num_r[W-1]};
    trial_sub = trial - {1'b0, span};
    ge        = (trial >= {1'b0, span});
    // subtract as add of the inverted magnitude with carry-in of one
    b_bit     = step_r[0] ^ neg_r;
    c_in      = ctrl.add_first ? neg_r : carry_r;
    s_bit     = acc_r[0] ^ b_bit ^ c_in;
    c_out     = (acc_r[0] & b_bit) | (acc_r[0] & c_in) | (b_bit & c_in);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      acc_r  <= {from_c, {FRAC_BITS{1'b0}}};
      num_r  <= {mag, {FRAC_BITS{1'b0}}};
      rem_r  <= '0;
      neg_r  <= (to_c < from_c);
      step_r <= '0;
    end else if (ctrl.div_step) begin
      num_r  <= {num_r[W-2:0], 1'b0};
      rem_r  <= ge ? trial_sub[CHAN_W-1:0] : trial[CHAN_W-1:0];
      step_r <= {step_r[W-2:0], ge};
    end else if (ctrl.add_step) begin
      acc_r   <= {s_bit, acc_r[W-1:1]};
      step_r  <= {step_r[0], step_r[W-1:1]};
      carry_r <= c_out;
    end
  end

  assign colour = acc_r[W-1 -: CHAN_W];

endmodule

/* hw/rtl/palette_gradient_ramp.sv */
// Top level of the palette gradient ramp: config registers, sequencer, output register.
// Depends on pgr_pkg and pgr_chan.
//
// Usage: write the end indices and end colours on the cfg channel (index 0..7,
// one 8-bit word each), then send words on the in_ channel. A word with
// in_tdata[0] set starts a new ramp and yields its first entry; a clear bit
// yields the next entry. With no ramp running a clear word yields nothing.
// Each result word carries index and RGB in out_tdata, the entry-zero
// transparency flag in out_tuser and the final entry of the ramp on out_tlast.
// The result sits in an output register in the cycle after acceptance.
// With W = 8 + FRAC_BITS (24 by default): a restart word over more than one
// entry holds in_tready low through bit-serial step division over W bits, one
// quotient bit a cycle for all three channels at once, then a bit-serial W-bit
// accumulator add; a continuing word through the serial add only; a word that
// ends the ramp, finds no ramp or restarts a single-entry range not at all.
// A stalled receiver holds the result; a new word is taken only once the
// output register is free or being emptied. Reset clears the sequencer and
// the ramp, and loads the config defaults (ramp 0..255, black to white).
module palette_gradient_ramp
  import pgr_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // config write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHAN_W-1:0]    cfg_data,
  // input words
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  // result words
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [7:0] entry_index, [15:8] red,
                                           // [23:16] green, [31:24] blue
  output logic                 out_tuser,  // [0] transparent
  output logic                 out_tlast   // last_entry
);

  localparam int W  = CHAN_W + FRAC_BITS;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  pgr_state_t state_r, state_nxt;
  pgr_ctrl_t  ctrl;

  logic [CW-1:0]     cnt_r;
  logic              active_r;
  logic [CHAN_W-1:0] cur_r, fin_r, span_r;

  logic [CHAN_W-1:0] first_r, last_r;
  logic [CHAN_W-1:0] s_red_r, s_green_r, s_blue_r;
  logic [CHAN_W-1:0] e_red_r, e_green_r, e_blue_r;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_idx_r, out_red_r, out_green_r, out_blue_r;
  logic              out_transp_r, out_last_r;

  logic              swap;
  logic [CHAN_W-1:0] lo, hi;
  logic [CHAN_W-1:0] r0, g0, b0, r1, g1, b1;
  logic [CHAN_W-1:0] col_red, col_green, col_blue;
  logic              accept, restart, emit, cont;

  // ---------------------------------------------------------------- config
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= '0;
      last_r    <= '1;
      s_red_r   <= '0;
      s_green_r <= '0;
      s_blue_r  <= '0;
      e_red_r   <= '1;
      e_green_r <= '1;
      e_blue_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_INDEX: first_r   <= cfg_data;
        REG_LAST_INDEX:  last_r    <= cfg_data;
        REG_START_RED:   s_red_r   <= cfg_data;
        REG_START_GREEN: s_green_r <= cfg_data;
        REG_START_BLUE:  s_blue_r  <= cfg_data;
        REG_END_RED:     e_red_r   <= cfg_data;
        REG_END_GREEN:   e_green_r <= cfg_data;
        REG_END_BLUE:    e_blue_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // reversed range runs from the end colour back to the start colour
  always_comb begin
    swap = first_r > last_r;
    lo   = swap ? last_r    : first_r;
    hi   = swap ? first_r   : last_r;
    r0   = swap ? e_red_r   : s_red_r;
    g0   = swap ? e_green_r : s_green_r;
    b0   = swap ? e_blue_r  : s_blue_r;
    r1   = swap ? s_red_r   : e_red_r;
    g1   = swap ? s_green_r : e_green_r;
    b1   = swap ? s_blue_r  : e_blue_r;
  end

  // ---------------------------------------------------------------- handshake
  assign in_tready = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tdata[0];
  assign emit      = accept && (restart || active_r);
  assign cont      = accept && !restart && active_r && (cur_r != fin_r);

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && restart && (lo != hi)) state_nxt = ST_DIV;
        else if (cont)                       state_nxt = ST_ADD;
      end
      ST_DIV: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (cnt_r == CNT_LAST) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.load      = accept && restart;
    ctrl.div_step  = (state_r == ST_DIV);
    ctrl.add_step  = (state_r == ST_ADD);
    ctrl.add_first = (state_r == ST_ADD) && (cnt_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      active_r    <= 1'b0;
      cur_r       <= '0;
      fin_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r != ST_IDLE) cnt_r <= (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
      else                    cnt_r <= '0;

      // cur_r is the entry the next continuing word emits
      if (accept && restart) begin
        active_r <= (lo != hi);
        cur_r    <= lo + 1'b1;
        fin_r    <= hi;
      end else if (accept && active_r) begin
        if (cur_r == fin_r) active_r <= 1'b0;
        else                cur_r    <= cur_r + 1'b1;
      end

      if (emit)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && restart) span_r <= hi - lo;
    if (emit) begin
      if (restart) begin
        out_idx_r    <= lo;
        out_red_r    <= r0;
        out_green_r  <= g0;
        out_blue_r   <= b0;
        out_transp_r <= (lo == '0);
        out_last_r   <= (lo == hi);
      end else begin
        out_idx_r    <= cur_r;
        out_red_r    <= col_red;
        out_green_r  <= col_green;
        out_blue_r   <= col_blue;
        out_transp_r <= (cur_r == '0);
        out_last_r   <= (cur_r == fin_r);
      end
    end
  end

  // ---------------------------------------------------------------- channels
  pgr_chan #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk(clk), .ctrl(ctrl), .from_c(r0), .to_c(r1), .span(span_r), .colour(col_red)
  );
  pgr_chan #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk(clk), .ctrl(ctrl), .from_c(g0), .to_c(g1), .span(span_r), .colour(col_green)
  );
  pgr_chan #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk(clk), .ctrl(ctrl), .from_c(b0), .to_c(b1), .span(span_r), .colour(col_blue)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_blue_r, out_green_r, out_red_r, out_idx_r};
  assign out_tuser  = out_transp_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------- checks
  a_div_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_LAST) |=> (state_r == ST_ADD))
    else $error("divide phase did not hand over to add phase");

  a_cont_adds: assert property (@(posedge clk) disable iff (!rst_n)
    cont |=> (state_r == ST_ADD && cur_r == CHAN_W'($past(cur_r) + 1'b1)))
    else $error("continuing word did not advance the ramp");

  a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (cur_r <= fin_r))
    else $error("ramp entry ran past the final entry");

  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("result word lost");

endmodule
